@@ sv/distance_constraint_solver_2d_assert.svh @@
// Assertion macros used by the distance constraint solver top level.
`ifndef DISTANCE_CONSTRAINT_SOLVER_2D_ASSERT_SVH
`define DISTANCE_CONSTRAINT_SOLVER_2D_ASSERT_SVH

// Same-cycle implication, checked on i_clk with reset masking.
`define DCS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("distance constraint solver check failed");

// Next-cycle implication, checked on i_clk with reset masking.
`define DCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("distance constraint solver check failed");

`endif

@@ sv/dcs_pkg.sv @@
// Shared widths, codes, latencies and types of the distance constraint solver.
package dcs_pkg;

    localparam int POS_W    = 32;
    localparam int MASS_W   = 16;
    localparam int DIFF_W   = POS_W + 1;
    localparam int MAG_W    = POS_W + 1;
    localparam int SH_W     = 31;
    localparam int SHIFT_W  = 2;
    localparam int SQ_W     = 2 * SH_W + 1;
    localparam int ROOT_W   = (SQ_W + 1) / 2;
    localparam int UNIT_Q   = 30;
    localparam int QUOT_W   = UNIT_Q + 1;
    localparam int UDEND_W  = SH_W + UNIT_Q;
    localparam int TOT_W    = MASS_W + 1;
    localparam int MDEND_W  = MASS_W + UNIT_Q;
    localparam int RATIO_Q  = 16;
    localparam int RATIO_W  = RATIO_Q + 1;
    localparam int RATIO_SH = UNIT_Q - RATIO_Q;
    localparam int REST_W   = 31;
    localparam int GAIN_W   = 17;
    localparam int GAIN_Q   = 16;
    localparam int LEN_W    = ROOT_W + 2;
    localparam int NUM_W    = LEN_W + 1;
    localparam int NMAG_W   = LEN_W;
    localparam int BASE_W   = NMAG_W;
    localparam int FULL_W   = BASE_W + 1;
    localparam int CORR_W   = FULL_W;
    localparam int SUM_W    = CORR_W + 2;

    localparam int MIN_LENGTH_LSB = 7;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE         = 2'd2;

    localparam logic [GAIN_W-1:0]  GAIN_ONE   = GAIN_W'(65536);
    localparam logic [RATIO_W-1:0] RATIO_HALF = RATIO_W'(32768);

    localparam int FRONT_LAT = 5;
    localparam int SQRT_LAT  = ROOT_W;
    localparam int DIV_LAT   = QUOT_W;
    localparam int CORR_LAT  = 7;
    localparam int ITEM_LAT  = FRONT_LAT + SQRT_LAT + DIV_LAT;
    localparam int MASS_TAP  = FRONT_LAT + SQRT_LAT - 1;

    typedef struct packed {
        logic signed [POS_W-1:0] a_x;
        logic signed [POS_W-1:0] a_y;
        logic signed [POS_W-1:0] b_x;
        logic signed [POS_W-1:0] b_y;
        logic [MASS_W-1:0]       a_mass;
        logic [MASS_W-1:0]       b_mass;
        logic                    a_pinned;
        logic                    b_pinned;
    } t_item;

    typedef struct packed {
        logic [SH_W-1:0]    sx;
        logic [SH_W-1:0]    sy;
        logic [SHIFT_W-1:0] s;
        logic               neg_x;
        logic               neg_y;
    } t_geom;

    typedef struct packed {
        logic [SQ_W-1:0] n;
        t_geom           geom;
    } t_front;

    typedef struct packed {
        logic [ROOT_W-1:0]  root;
        logic [SHIFT_W-1:0] s;
        logic               neg_x;
        logic               neg_y;
    } t_post;

    typedef struct packed {
        logic [REST_W-1:0] rest_length;
        logic [GAIN_W-1:0] stiffness_gain;
        logic              enable;
    } t_cfg;

    typedef struct packed {
        logic signed [POS_W-1:0] new_a_x;
        logic signed [POS_W-1:0] new_a_y;
        logic signed [POS_W-1:0] new_b_x;
        logic signed [POS_W-1:0] new_b_y;
        logic                    applied;
        logic                    saturated;
    } t_result;

endpackage

@@ sv/distance_constraint_solver_2d.sv @@
// Top level of the pipelined 2D distance constraint solver.
//
//   Channel   Handshake                       Payload
//   --------  ------------------------------  ---------------------------------------
//   request   start, busy (accept: start&!busy) i_a_x i_a_y i_b_x i_b_y i_a_mass ...
//   result    o_done (one-cycle strobe)       o_new_a_x .. o_new_b_y o_applied o_saturated
//   config    i_cfg_valid, o_cfg_ready        i_cfg_index, i_cfg_data
//
// A request can be accepted in every cycle; busy is high during reset and in the
// first cycle after it.
// Each result passes 5 front, 32 square root, 31 divider and 7 correction stages.
// Reset is synchronous and active low; it clears the valid bits and resets the config registers.
// Results cannot be held off, so the pipeline never stalls and nothing is lost.
module distance_constraint_solver_2d (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [dcs_pkg::POS_W-1:0]     i_a_x,
    input  logic signed [dcs_pkg::POS_W-1:0]     i_a_y,
    input  logic signed [dcs_pkg::POS_W-1:0]     i_b_x,
    input  logic signed [dcs_pkg::POS_W-1:0]     i_b_y,
    input  logic [dcs_pkg::MASS_W-1:0]           i_a_mass,
    input  logic [dcs_pkg::MASS_W-1:0]           i_b_mass,
    input  logic                                 i_a_pinned,
    input  logic                                 i_b_pinned,
    output logic                                 o_done,
    output logic signed [dcs_pkg::POS_W-1:0]     o_new_a_x,
    output logic signed [dcs_pkg::POS_W-1:0]     o_new_a_y,
    output logic signed [dcs_pkg::POS_W-1:0]     o_new_b_x,
    output logic signed [dcs_pkg::POS_W-1:0]     o_new_b_y,
    output logic                                 o_applied,
    output logic                                 o_saturated,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dcs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [dcs_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

`include "distance_constraint_solver_2d_assert.svh"

    logic          r_busy;
    dcs_pkg::t_cfg r_cfg;
    logic          accept;

    // The request payload travels alongside the arithmetic so that the
    // positions and masses reach the stage that needs them.
    logic [dcs_pkg::ITEM_LAT-1:0] r_vld_line;
    dcs_pkg::t_item               r_item_line [dcs_pkg::ITEM_LAT];
    dcs_pkg::t_geom               r_geom_line [dcs_pkg::SQRT_LAT];
    dcs_pkg::t_post               r_post_line [dcs_pkg::DIV_LAT];
    dcs_pkg::t_item               n_item;

    dcs_pkg::t_front                     front;
    logic [dcs_pkg::ROOT_W-1:0]          root;
    logic [dcs_pkg::QUOT_W-1:0]          ex, ey, ra_q, rb_q;
    logic                                corr_valid;
    dcs_pkg::t_result                    result;
    dcs_pkg::t_post                      n_post;

    assign accept      = start && !busy;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    assign n_item.a_x      = i_a_x;
    assign n_item.a_y      = i_a_y;
    assign n_item.b_x      = i_b_x;
    assign n_item.b_y      = i_b_y;
    assign n_item.a_mass   = i_a_mass;
    assign n_item.b_mass   = i_b_mass;
    assign n_item.a_pinned = i_a_pinned;
    assign n_item.b_pinned = i_b_pinned;

    assign n_post.root  = root;
    assign n_post.s     = r_geom_line[dcs_pkg::SQRT_LAT-1].s;
    assign n_post.neg_x = r_geom_line[dcs_pkg::SQRT_LAT-1].neg_x;
    assign n_post.neg_y = r_geom_line[dcs_pkg::SQRT_LAT-1].neg_y;

    // Config registers; the user must make writes only while the pipeline is empty; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy                <= 1'b1;
            r_cfg.rest_length     <= '0;
            r_cfg.stiffness_gain  <= dcs_pkg::GAIN_ONE;
            r_cfg.enable          <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    dcs_pkg::CFG_REST_LENGTH: begin
                        r_cfg.rest_length <= i_cfg_data[dcs_pkg::REST_W-1:0];
                    end
                    dcs_pkg::CFG_STIFFNESS_GAIN: begin
                        r_cfg.stiffness_gain <= i_cfg_data[dcs_pkg::GAIN_W-1:0];
                    end
                    dcs_pkg::CFG_ENABLE: begin
                        r_cfg.enable <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_line <= '0;
        end else begin
            r_vld_line <= {r_vld_line[dcs_pkg::ITEM_LAT-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_item_line[0] <= n_item;
        for (int k = 1; k < dcs_pkg::ITEM_LAT; k++) begin
            r_item_line[k] <= r_item_line[k-1];
        end
        r_geom_line[0] <= front.geom;
        for (int k = 1; k < dcs_pkg::SQRT_LAT; k++) begin
            r_geom_line[k] <= r_geom_line[k-1];
        end
        r_post_line[0] <= n_post;
        for (int k = 1; k < dcs_pkg::DIV_LAT; k++) begin
            r_post_line[k] <= r_post_line[k-1];
        end
    end

    dcs_front u_front (
        .i_clk   (i_clk),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_b_x   (i_b_x),
        .i_b_y   (i_b_y),
        .o_front (front)
    );

    dcs_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_n    (front.n),
        .o_root (root)
    );

    // Unit vector component magnitudes in unsigned Q1.30.
    dcs_divide #(
        .DEND_W (dcs_pkg::UDEND_W),
        .DSOR_W (dcs_pkg::ROOT_W),
        .QUOT_W (dcs_pkg::QUOT_W)
    ) u_div_x (
        .i_clk      (i_clk),
        .i_dividend (dcs_pkg::UDEND_W'(r_geom_line[dcs_pkg::SQRT_LAT-1].sx) << dcs_pkg::UNIT_Q),
        .i_divisor  (root),
        .o_quot     (ex)
    );

    dcs_divide #(
        .DEND_W (dcs_pkg::UDEND_W),
        .DSOR_W (dcs_pkg::ROOT_W),
        .QUOT_W (dcs_pkg::QUOT_W)
    ) u_div_y (
        .i_clk      (i_clk),
        .i_dividend (dcs_pkg::UDEND_W'(r_geom_line[dcs_pkg::SQRT_LAT-1].sy) << dcs_pkg::UNIT_Q),
        .i_divisor  (root),
        .o_quot     (ey)
    );

    // Mass ratios are formed with 30 fraction bits and trimmed to 16 later,
    // which gives the same floor as dividing at 16 bits directly.
    dcs_divide #(
        .DEND_W (dcs_pkg::MDEND_W),
        .DSOR_W (dcs_pkg::TOT_W),
        .QUOT_W (dcs_pkg::QUOT_W)
    ) u_div_ra (
        .i_clk      (i_clk),
        .i_dividend (dcs_pkg::MDEND_W'(r_item_line[dcs_pkg::MASS_TAP].b_mass) << dcs_pkg::UNIT_Q),
        .i_divisor  (dcs_pkg::TOT_W'(r_item_line[dcs_pkg::MASS_TAP].a_mass)
                     + dcs_pkg::TOT_W'(r_item_line[dcs_pkg::MASS_TAP].b_mass)),
        .o_quot     (ra_q)
    );

    dcs_divide #(
        .DEND_W (dcs_pkg::MDEND_W),
        .DSOR_W (dcs_pkg::TOT_W),
        .QUOT_W (dcs_pkg::QUOT_W)
    ) u_div_rb (
        .i_clk      (i_clk),
        .i_dividend (dcs_pkg::MDEND_W'(r_item_line[dcs_pkg::MASS_TAP].a_mass) << dcs_pkg::UNIT_Q),
        .i_divisor  (dcs_pkg::TOT_W'(r_item_line[dcs_pkg::MASS_TAP].a_mass)
                     + dcs_pkg::TOT_W'(r_item_line[dcs_pkg::MASS_TAP].b_mass)),
        .o_quot     (rb_q)
    );

    dcs_correct u_correct (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld_line[dcs_pkg::ITEM_LAT-1]),
        .i_item   (r_item_line[dcs_pkg::ITEM_LAT-1]),
        .i_post   (r_post_line[dcs_pkg::DIV_LAT-1]),
        .i_ex     (ex),
        .i_ey     (ey),
        .i_ra_q   (ra_q),
        .i_rb_q   (rb_q),
        .i_cfg    (r_cfg),
        .o_valid  (corr_valid),
        .o_result (result)
    );

    assign o_done      = corr_valid;
    assign o_new_a_x   = result.new_a_x;
    assign o_new_a_y   = result.new_a_y;
    assign o_new_b_x   = result.new_b_x;
    assign o_new_b_y   = result.new_b_y;
    assign o_applied   = result.applied;
    assign o_saturated = result.saturated;

    // An accepted request enters the valid line on the next edge.
    `DCS_ASSERT_NEXT(a_accept_enters, accept, r_vld_line[0])
    // Every result strobe traces back to a request leaving the divider stages.
    `DCS_ASSERT_IMP(a_done_traced, o_done, $past(r_vld_line[dcs_pkg::ITEM_LAT-1], dcs_pkg::CORR_LAT))
    // A passed-through request can never report clamping.
    `DCS_ASSERT_IMP(a_sat_needs_apply, o_done && !o_applied, !o_saturated)

endmodule

@@ sv/dcs_front.sv @@
// Front end: differences, magnitudes, range shift, squares and their sum.
module dcs_front (
    input  logic                            i_clk,
    input  logic signed [dcs_pkg::POS_W-1:0] i_a_x,
    input  logic signed [dcs_pkg::POS_W-1:0] i_a_y,
    input  logic signed [dcs_pkg::POS_W-1:0] i_b_x,
    input  logic signed [dcs_pkg::POS_W-1:0] i_b_y,
    output dcs_pkg::t_front                 o_front
);

    logic signed [dcs_pkg::DIFF_W-1:0] r_dx, r_dy;
    logic [dcs_pkg::MAG_W-1:0]         r_ux, r_uy;
    logic                              r2_negx, r2_negy;
    dcs_pkg::t_geom                    r3_geom, r4_geom, r5_geom;
    logic [2*dcs_pkg::SH_W-1:0]        r_sqx, r_sqy;
    logic [dcs_pkg::SQ_W-1:0]          r_n;
    logic [dcs_pkg::SHIFT_W-1:0]       s_sel;

    // The scaled magnitudes must stay below 2^31 before squaring.
    always_comb begin
        if (r_ux[dcs_pkg::MAG_W-1] || r_uy[dcs_pkg::MAG_W-1]) begin
            s_sel = dcs_pkg::SHIFT_W'(2);
        end else if (r_ux[dcs_pkg::MAG_W-2] || r_uy[dcs_pkg::MAG_W-2]) begin
            s_sel = dcs_pkg::SHIFT_W'(1);
        end else begin
            s_sel = dcs_pkg::SHIFT_W'(0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx    <= dcs_pkg::DIFF_W'(i_b_x) - dcs_pkg::DIFF_W'(i_a_x);
        r_dy    <= dcs_pkg::DIFF_W'(i_b_y) - dcs_pkg::DIFF_W'(i_a_y);
        r_ux    <= r_dx[dcs_pkg::DIFF_W-1] ? dcs_pkg::MAG_W'(-r_dx) : dcs_pkg::MAG_W'(r_dx);
        r_uy    <= r_dy[dcs_pkg::DIFF_W-1] ? dcs_pkg::MAG_W'(-r_dy) : dcs_pkg::MAG_W'(r_dy);
        r2_negx <= r_dx[dcs_pkg::DIFF_W-1];
        r2_negy <= r_dy[dcs_pkg::DIFF_W-1];
        r3_geom.sx    <= dcs_pkg::SH_W'(r_ux >> s_sel);
        r3_geom.sy    <= dcs_pkg::SH_W'(r_uy >> s_sel);
        r3_geom.s     <= s_sel;
        r3_geom.neg_x <= r2_negx;
        r3_geom.neg_y <= r2_negy;
        r_sqx   <= r3_geom.sx * r3_geom.sx;
        r_sqy   <= r3_geom.sy * r3_geom.sy;
        r4_geom <= r3_geom;
        r_n     <= dcs_pkg::SQ_W'(r_sqx) + dcs_pkg::SQ_W'(r_sqy);
        r5_geom <= r4_geom;
    end

    assign o_front.n    = r_n;
    assign o_front.geom = r5_geom;

endmodule

@@ sv/dcs_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module dcs_isqrt (
    input  logic                         i_clk,
    input  logic [dcs_pkg::SQ_W-1:0]     i_n,
    output logic [dcs_pkg::ROOT_W-1:0]   o_root
);

    logic [dcs_pkg::SQ_W-1:0] r_rem [dcs_pkg::ROOT_W];
    logic [dcs_pkg::SQ_W-1:0] r_res [dcs_pkg::ROOT_W];

    genvar k;
    for (k = 0; k < dcs_pkg::ROOT_W; k++) begin : g_step
        localparam logic [dcs_pkg::SQ_W-1:0] BIT_V =
            dcs_pkg::SQ_W'(1) << (dcs_pkg::SQ_W - 1 - 2 * k);
        logic [dcs_pkg::SQ_W-1:0] rem_in, res_in, trial;

        if (k == 0) begin : g_first
            assign rem_in = i_n;
            assign res_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign res_in = r_res[k-1];
        end

        assign trial = res_in + BIT_V;

        always_ff @(posedge i_clk) begin
            if (rem_in >= trial) begin
                r_rem[k] <= rem_in - trial;
                r_res[k] <= (res_in >> 1) + BIT_V;
            end else begin
                r_rem[k] <= rem_in;
                r_res[k] <= res_in >> 1;
            end
        end
    end

    assign o_root = r_res[dcs_pkg::ROOT_W-1][dcs_pkg::ROOT_W-1:0];

endmodule

@@ sv/dcs_divide.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module dcs_divide #(
    parameter int DEND_W = dcs_pkg::UDEND_W,
    parameter int DSOR_W = dcs_pkg::ROOT_W,
    parameter int QUOT_W = dcs_pkg::QUOT_W
) (
    input  logic              i_clk,
    input  logic [DEND_W-1:0] i_dividend,
    input  logic [DSOR_W-1:0] i_divisor,
    output logic [QUOT_W-1:0] o_quot
);

    // The upper dividend bits are known to be below the divisor, so only
    // QUOT_W quotient bits are developed.
    logic [DSOR_W-1:0] r_rem  [QUOT_W];
    logic [QUOT_W-1:0] r_work [QUOT_W];
    logic [DSOR_W-1:0] r_dsor [QUOT_W];

    genvar k;
    for (k = 0; k < QUOT_W; k++) begin : g_step
        logic [DSOR_W-1:0] rem_in, dsor_in;
        logic [QUOT_W-1:0] work_in;
        logic [DSOR_W:0]   shifted, diff;

        if (k == 0) begin : g_first
            assign rem_in  = DSOR_W'(i_dividend[DEND_W-1:QUOT_W]);
            assign work_in = i_dividend[QUOT_W-1:0];
            assign dsor_in = i_divisor;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign work_in = r_work[k-1];
            assign dsor_in = r_dsor[k-1];
        end

        assign shifted = {rem_in, work_in[QUOT_W-1]};
        assign diff    = shifted - {1'b0, dsor_in};

        always_ff @(posedge i_clk) begin
            if (shifted >= {1'b0, dsor_in}) begin
                r_rem[k]  <= diff[DSOR_W-1:0];
                r_work[k] <= {work_in[QUOT_W-2:0], 1'b1};
            end else begin
                r_rem[k]  <= shifted[DSOR_W-1:0];
                r_work[k] <= {work_in[QUOT_W-2:0], 1'b0};
            end
            r_dsor[k] <= dsor_in;
        end
    end

    assign o_quot = r_work[QUOT_W-1];

endmodule

@@ sv/dcs_correct.sv @@
// Correction back end: length error, projection, gain, mass split and clamp.
module dcs_correct (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  dcs_pkg::t_item                    i_item,
    input  dcs_pkg::t_post                    i_post,
    input  logic [dcs_pkg::QUOT_W-1:0]        i_ex,
    input  logic [dcs_pkg::QUOT_W-1:0]        i_ey,
    input  logic [dcs_pkg::QUOT_W-1:0]        i_ra_q,
    input  logic [dcs_pkg::QUOT_W-1:0]        i_rb_q,
    input  dcs_pkg::t_cfg                     i_cfg,
    output logic                              o_valid,
    output dcs_pkg::t_result                  o_result
);

    typedef struct packed {
        logic signed [dcs_pkg::POS_W-1:0] a_x;
        logic signed [dcs_pkg::POS_W-1:0] a_y;
        logic signed [dcs_pkg::POS_W-1:0] b_x;
        logic signed [dcs_pkg::POS_W-1:0] b_y;
        logic                             active;
        logic                             move_a;
        logic                             move_b;
        logic                             both_free;
        logic [dcs_pkg::RATIO_W-1:0]      ra;
        logic [dcs_pkg::RATIO_W-1:0]      rb;
    } t_ctl;

    logic [dcs_pkg::CORR_LAT-1:0] r_vld;
    t_ctl r1_ctl, r2_ctl, r3_ctl, r4_ctl, r5_ctl, r6_ctl;

    logic [dcs_pkg::LEN_W-1:0]        len;
    logic signed [dcs_pkg::NUM_W-1:0] len_s, rest_s;
    logic                             tot_zero;
    t_ctl                             n_ctl;

    logic signed [dcs_pkg::NUM_W-1:0] r1_num;
    logic [dcs_pkg::QUOT_W-1:0]       r1_ex, r1_ey, r2_ex, r2_ey;
    logic                             r1_negx, r1_negy, r2_negx, r2_negy;
    logic [dcs_pkg::NMAG_W-1:0]       r2_nmag;
    logic                             r2_nneg;
    logic [dcs_pkg::NMAG_W+dcs_pkg::QUOT_W-1:0] prod_x, prod_y;
    logic [dcs_pkg::BASE_W-1:0]       r3_bx, r3_by;
    logic                             r3_negx, r3_negy, r4_negx, r4_negy, r5_negx, r5_negy;
    logic [dcs_pkg::BASE_W+dcs_pkg::GAIN_W-1:0] g_x, g_y;
    logic [dcs_pkg::FULL_W-1:0]       r4_hx, r4_hy;
    logic [dcs_pkg::FULL_W+dcs_pkg::RATIO_W-1:0] p_ax, p_ay, p_bx, p_by;
    logic [dcs_pkg::CORR_W-1:0]       c_ax, c_ay, c_bx, c_by;
    logic [dcs_pkg::CORR_W-1:0]       r5_ax, r5_ay, r5_bx, r5_by;
    logic signed [dcs_pkg::SUM_W-1:0] e_ax, e_ay, e_bx, e_by;
    logic signed [dcs_pkg::SUM_W-1:0] r6_ax, r6_ay, r6_bx, r6_by;
    logic [dcs_pkg::POS_W:0]          k_ax, k_ay, k_bx, k_by;
    dcs_pkg::t_result                 r_result;

    // Returns the saturation flag above the clamped coordinate.
    function automatic logic [dcs_pkg::POS_W:0] clamp_pos(
        input logic signed [dcs_pkg::SUM_W-1:0] v
    );
        logic [dcs_pkg::SUM_W-dcs_pkg::POS_W:0] top;
        top = v[dcs_pkg::SUM_W-1:dcs_pkg::POS_W-1];
        if (top == '0 || top == '1) begin
            return {1'b0, v[dcs_pkg::POS_W-1:0]};
        end else if (v[dcs_pkg::SUM_W-1]) begin
            return {1'b1, 1'b1, {(dcs_pkg::POS_W-1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(dcs_pkg::POS_W-1){1'b1}}};
        end
    endfunction

    always_comb begin
        len      = dcs_pkg::LEN_W'(i_post.root) << i_post.s;
        len_s    = dcs_pkg::NUM_W'(len);
        rest_s   = dcs_pkg::NUM_W'(i_cfg.rest_length);
        tot_zero = (i_item.a_mass == '0) && (i_item.b_mass == '0);
        n_ctl.a_x    = i_item.a_x;
        n_ctl.a_y    = i_item.a_y;
        n_ctl.b_x    = i_item.b_x;
        n_ctl.b_y    = i_item.b_y;
        n_ctl.active = i_cfg.enable && !(i_item.a_pinned && i_item.b_pinned)
                       && (len >= dcs_pkg::LEN_W'(dcs_pkg::MIN_LENGTH_LSB));
        n_ctl.move_a    = n_ctl.active && !i_item.a_pinned;
        n_ctl.move_b    = n_ctl.active && !i_item.b_pinned;
        n_ctl.both_free = !i_item.a_pinned && !i_item.b_pinned;
        n_ctl.ra = tot_zero ? dcs_pkg::RATIO_HALF
                            : dcs_pkg::RATIO_W'(i_ra_q >> dcs_pkg::RATIO_SH);
        n_ctl.rb = tot_zero ? dcs_pkg::RATIO_HALF
                            : dcs_pkg::RATIO_W'(i_rb_q >> dcs_pkg::RATIO_SH);
    end

    assign prod_x = r2_nmag * r2_ex;
    assign prod_y = r2_nmag * r2_ey;
    assign g_x    = r3_bx * i_cfg.stiffness_gain;
    assign g_y    = r3_by * i_cfg.stiffness_gain;
    assign p_ax   = r4_hx * r4_ctl.ra;
    assign p_ay   = r4_hy * r4_ctl.ra;
    assign p_bx   = r4_hx * r4_ctl.rb;
    assign p_by   = r4_hy * r4_ctl.rb;

    always_comb begin
        if (r4_ctl.both_free) begin
            c_ax = dcs_pkg::CORR_W'(p_ax >> dcs_pkg::RATIO_Q);
            c_ay = dcs_pkg::CORR_W'(p_ay >> dcs_pkg::RATIO_Q);
            c_bx = dcs_pkg::CORR_W'(p_bx >> dcs_pkg::RATIO_Q);
            c_by = dcs_pkg::CORR_W'(p_by >> dcs_pkg::RATIO_Q);
        end else begin
            c_ax = r4_hx;
            c_ay = r4_hy;
            c_bx = r4_hx;
            c_by = r4_hy;
        end
        e_ax = $signed(dcs_pkg::SUM_W'(r5_ax));
        e_ay = $signed(dcs_pkg::SUM_W'(r5_ay));
        e_bx = $signed(dcs_pkg::SUM_W'(r5_bx));
        e_by = $signed(dcs_pkg::SUM_W'(r5_by));
        k_ax = clamp_pos(r6_ax);
        k_ay = clamp_pos(r6_ay);
        k_bx = clamp_pos(r6_bx);
        k_by = clamp_pos(r6_by);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[dcs_pkg::CORR_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ctl  <= n_ctl;
        r1_num  <= len_s - rest_s;
        r1_ex   <= i_ex;
        r1_ey   <= i_ey;
        r1_negx <= i_post.neg_x;
        r1_negy <= i_post.neg_y;

        r2_ctl  <= r1_ctl;
        r2_nmag <= r1_num[dcs_pkg::NUM_W-1] ? dcs_pkg::NMAG_W'(-r1_num)
                                            : dcs_pkg::NMAG_W'(r1_num);
        r2_nneg <= r1_num[dcs_pkg::NUM_W-1];
        r2_ex   <= r1_ex;
        r2_ey   <= r1_ey;
        r2_negx <= r1_negx;
        r2_negy <= r1_negy;

        r3_ctl  <= r2_ctl;
        r3_bx   <= prod_x[dcs_pkg::UNIT_Q +: dcs_pkg::BASE_W];
        r3_by   <= prod_y[dcs_pkg::UNIT_Q +: dcs_pkg::BASE_W];
        r3_negx <= r2_nneg ^ r2_negx;
        r3_negy <= r2_nneg ^ r2_negy;

        r4_ctl  <= r3_ctl;
        r4_hx   <= r3_ctl.both_free ? dcs_pkg::FULL_W'(g_x >> (dcs_pkg::GAIN_Q + 1))
                                    : dcs_pkg::FULL_W'(g_x >> dcs_pkg::GAIN_Q);
        r4_hy   <= r3_ctl.both_free ? dcs_pkg::FULL_W'(g_y >> (dcs_pkg::GAIN_Q + 1))
                                    : dcs_pkg::FULL_W'(g_y >> dcs_pkg::GAIN_Q);
        r4_negx <= r3_negx;
        r4_negy <= r3_negy;

        r5_ctl  <= r4_ctl;
        r5_ax   <= r4_ctl.move_a ? c_ax : '0;
        r5_ay   <= r4_ctl.move_a ? c_ay : '0;
        r5_bx   <= r4_ctl.move_b ? c_bx : '0;
        r5_by   <= r4_ctl.move_b ? c_by : '0;
        r5_negx <= r4_negx;
        r5_negy <= r4_negy;

        // A moves along the correction, B against it.
        r6_ctl <= r5_ctl;
        r6_ax  <= r5_negx ? dcs_pkg::SUM_W'(r5_ctl.a_x) - e_ax
                          : dcs_pkg::SUM_W'(r5_ctl.a_x) + e_ax;
        r6_ay  <= r5_negy ? dcs_pkg::SUM_W'(r5_ctl.a_y) - e_ay
                          : dcs_pkg::SUM_W'(r5_ctl.a_y) + e_ay;
        r6_bx  <= r5_negx ? dcs_pkg::SUM_W'(r5_ctl.b_x) + e_bx
                          : dcs_pkg::SUM_W'(r5_ctl.b_x) - e_bx;
        r6_by  <= r5_negy ? dcs_pkg::SUM_W'(r5_ctl.b_y) + e_by
                          : dcs_pkg::SUM_W'(r5_ctl.b_y) - e_by;

        r_result.new_a_x   <= k_ax[dcs_pkg::POS_W-1:0];
        r_result.new_a_y   <= k_ay[dcs_pkg::POS_W-1:0];
        r_result.new_b_x   <= k_bx[dcs_pkg::POS_W-1:0];
        r_result.new_b_y   <= k_by[dcs_pkg::POS_W-1:0];
        r_result.applied   <= r6_ctl.active;
        r_result.saturated <= k_ax[dcs_pkg::POS_W] | k_ay[dcs_pkg::POS_W]
                            | k_bx[dcs_pkg::POS_W] | k_by[dcs_pkg::POS_W];
    end

    assign o_valid  = r_vld[dcs_pkg::CORR_LAT-1];
    assign o_result = r_result;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench of the 2D distance constraint solver, with its own predictor.
module tb_top;

    // Each result comes a fixed pipeline depth after its request; drains allow for that.
    localparam int DRAIN_CYCLES = 80;
    // The watchdog trips after this many cycles with no handshake of any kind.
    localparam int STALL_LIMIT  = 1500;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic signed [dcs_pkg::POS_W-1:0]  i_a_x, i_a_y, i_b_x, i_b_y;
    logic [dcs_pkg::MASS_W-1:0]        i_a_mass, i_b_mass;
    logic                              i_a_pinned, i_b_pinned;
    logic                              o_done;
    logic signed [dcs_pkg::POS_W-1:0]  o_new_a_x, o_new_a_y, o_new_b_x, o_new_b_y;
    logic                              o_applied, o_saturated;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [dcs_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [dcs_pkg::CFG_DATA_W-1:0]    i_cfg_data;

    distance_constraint_solver_2d u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_a_x       (i_a_x),
        .i_a_y       (i_a_y),
        .i_b_x       (i_b_x),
        .i_b_y       (i_b_y),
        .i_a_mass    (i_a_mass),
        .i_b_mass    (i_b_mass),
        .i_a_pinned  (i_a_pinned),
        .i_b_pinned  (i_b_pinned),
        .o_done      (o_done),
        .o_new_a_x   (o_new_a_x),
        .o_new_a_y   (o_new_a_y),
        .o_new_b_x   (o_new_b_x),
        .o_new_b_y   (o_new_b_y),
        .o_applied   (o_applied),
        .o_saturated (o_saturated),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a period of 10 time units.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Our own copy of the configuration registers, updated at each accepted write.
    dcs_pkg::t_cfg      solver_cfg;
    // Corrected positions still owed by the block, oldest first.
    dcs_pkg::t_result   pending_positions[$];
    int                 error_count;
    bit                 idle_free;     // When set, the sender requests back to back.

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Integer square root, floor, by the bitwise method.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Scales a by b and shifts right, truncating the magnitude; saturates to 63 bits.
    function automatic longint scale_trunc(longint a, longint unsigned b, int sh);
        logic [127:0]    prod;
        longint unsigned ua;
        ua   = (a < 0) ? longint'(-a) : longint'(a);
        prod = ({64'd0, ua} * {64'd0, b}) >> sh;
        if (prod > 128'h7FFF_FFFF_FFFF_FFFF) prod = 128'h7FFF_FFFF_FFFF_FFFF;
        return (a < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic logic [dcs_pkg::POS_W-1:0] clamp_pos(longint v, inout bit sat);
        if (v > 64'sd2147483647) begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[dcs_pkg::POS_W-1:0];
    endfunction

    // Unit vector component in Q2.30 with the sign of the difference.
    function automatic longint unit_part(longint d, longint unsigned scaled, longint unsigned r);
        longint unsigned q;
        q = (scaled << dcs_pkg::UNIT_Q) / r;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint project(longint num, longint e);
        longint mag;
        mag = scale_trunc(num, (e < 0) ? -e : e, dcs_pkg::UNIT_Q);
        return (e < 0) ? -mag : mag;
    endfunction

    function automatic dcs_pkg::t_result predict_pair(dcs_pkg::t_item it, dcs_pkg::t_cfg cfg);
        dcs_pkg::t_result res;
        longint          ax, ay, bx, by, dx, dy, num, ex, ey, basex, basey;
        longint          hx, hy, fx, fy;
        longint unsigned udx, udy, span, sx, sy, r, len, tot, ra, rb;
        int              s;
        bit              sat;
        ax = longint'($signed(it.a_x));
        ay = longint'($signed(it.a_y));
        bx = longint'($signed(it.b_x));
        by = longint'($signed(it.b_y));
        dx = bx - ax;
        dy = by - ay;
        udx  = (dx < 0) ? -dx : dx;
        udy  = (dy < 0) ? -dy : dy;
        span = (udx > udy) ? udx : udy;
        s = 0;
        while ((span >> s) >= (64'd1 << 31)) s++;
        sx  = udx >> s;
        sy  = udy >> s;
        r   = int_sqrt(sx * sx + sy * sy);
        len = r << s;
        sat = 1'b0;
        res.new_a_x   = it.a_x;
        res.new_a_y   = it.a_y;
        res.new_b_x   = it.b_x;
        res.new_b_y   = it.b_y;
        res.applied   = 1'b0;
        if (cfg.enable && !(it.a_pinned && it.b_pinned) && len >= dcs_pkg::MIN_LENGTH_LSB
            && r != 0) begin
            num   = longint'(len) - longint'(cfg.rest_length);
            ex    = unit_part(dx, sx, r);
            ey    = unit_part(dy, sy, r);
            basex = project(num, ex);
            basey = project(num, ey);
            res.applied = 1'b1;
            if (!it.a_pinned && !it.b_pinned) begin
                tot = it.a_mass + it.b_mass;
                ra  = (tot != 0) ? (longint'(it.b_mass) << dcs_pkg::RATIO_Q) / tot : 32768;
                rb  = (tot != 0) ? (longint'(it.a_mass) << dcs_pkg::RATIO_Q) / tot : 32768;
                hx  = scale_trunc(basex, cfg.stiffness_gain, dcs_pkg::GAIN_Q + 1);
                hy  = scale_trunc(basey, cfg.stiffness_gain, dcs_pkg::GAIN_Q + 1);
                res.new_a_x = clamp_pos(ax + scale_trunc(hx, ra, dcs_pkg::RATIO_Q), sat);
                res.new_a_y = clamp_pos(ay + scale_trunc(hy, ra, dcs_pkg::RATIO_Q), sat);
                res.new_b_x = clamp_pos(bx - scale_trunc(hx, rb, dcs_pkg::RATIO_Q), sat);
                res.new_b_y = clamp_pos(by - scale_trunc(hy, rb, dcs_pkg::RATIO_Q), sat);
            end else begin
                // Only one particle is free, so it takes the whole correction.
                fx = scale_trunc(basex, cfg.stiffness_gain, dcs_pkg::GAIN_Q);
                fy = scale_trunc(basey, cfg.stiffness_gain, dcs_pkg::GAIN_Q);
                if (!it.a_pinned) begin
                    res.new_a_x = clamp_pos(ax + fx, sat);
                    res.new_a_y = clamp_pos(ay + fy, sat);
                end else begin
                    res.new_b_x = clamp_pos(bx - fx, sat);
                    res.new_b_y = clamp_pos(by - fy, sat);
                end
            end
        end
        res.saturated = sat;
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if (idle_free) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(10, 60);
    endfunction

    // Sends one request and records the positions it should produce.
    task automatic send_request(dcs_pkg::t_item it);
        int gap;
        start      <= 1'b1;
        i_a_x      <= it.a_x;
        i_a_y      <= it.a_y;
        i_b_x      <= it.b_x;
        i_b_y      <= it.b_y;
        i_a_mass   <= it.a_mass;
        i_b_mass   <= it.b_mass;
        i_a_pinned <= it.a_pinned;
        i_b_pinned <= it.b_pinned;
        do @(posedge i_clk); while (busy);
        pending_positions.push_back(predict_pair(it, solver_cfg));
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Writes one register; the data may carry junk above the register width.
    // The caller drops the valid after its last write.
    task automatic write_reg(logic [dcs_pkg::CFG_IDX_W-1:0] idx,
                             logic [dcs_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            dcs_pkg::CFG_REST_LENGTH:
                solver_cfg.rest_length    = data[dcs_pkg::REST_W-1:0];
            dcs_pkg::CFG_STIFFNESS_GAIN:
                solver_cfg.stiffness_gain = data[dcs_pkg::GAIN_W-1:0];
            dcs_pkg::CFG_ENABLE:
                solver_cfg.enable         = data[0];
            default: ;
        endcase
    endtask

    // Lets every outstanding result come back, then a full pipeline of quiet cycles.
    task automatic drain_pipeline();
        start <= 1'b0;
        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [dcs_pkg::REST_W-1:0] rest,
                                 logic [dcs_pkg::GAIN_W-1:0] gain, logic en);
        drain_pipeline();
        write_reg(dcs_pkg::CFG_REST_LENGTH, {$urandom_range(0, 1) == 1, rest});
        write_reg(dcs_pkg::CFG_STIFFNESS_GAIN, {15'($urandom), gain});
        write_reg(dcs_pkg::CFG_ENABLE, {31'($urandom), en});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic dcs_pkg::t_item make_item(longint ax, longint ay, longint bx, longint by,
                                                 int ma, int mb, bit pa, bit pb);
        dcs_pkg::t_item it;
        it.a_x = ax[31:0];
        it.a_y = ay[31:0];
        it.b_x = bx[31:0];
        it.b_y = by[31:0];
        it.a_mass = ma[15:0];
        it.b_mass = mb[15:0];
        it.a_pinned = pa;
        it.b_pinned = pb;
        return it;
    endfunction

    // Random pair: mostly close together, sometimes anywhere in the range.
    function automatic dcs_pkg::t_item random_pair();
        dcs_pkg::t_item it;
        int    reach;
        it.a_x = $urandom;
        it.a_y = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            it.b_x = $urandom;
            it.b_y = $urandom;
        end else begin
            reach  = 1 << $urandom_range(2, 24);
            it.b_x = it.a_x + $urandom_range(0, 2 * reach) - reach;
            it.b_y = it.a_y + $urandom_range(0, 2 * reach) - reach;
        end
        it.a_mass   = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 1)) : 16'($urandom);
        it.b_mass   = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 1)) : 16'($urandom);
        it.a_pinned = ($urandom_range(0, 3) == 0);
        it.b_pinned = ($urandom_range(0, 3) == 0);
        return it;
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Extremes of the fields and each special case, first under the reset settings, then under others.
    task automatic test_directed();
        send_request(make_item(0, 0, 0, 0, 256, 256, 0, 0));            // coincident
        send_request(make_item(0, 0, 6, 0, 256, 256, 0, 0));            // below minimum length
        send_request(make_item(0, 0, 7, 0, 256, 256, 0, 0));            // at minimum length
        send_request(make_item(100, 200, 65536, -65536, 1, 65535, 0, 0));
        send_request(make_item(100, 200, 65536, -65536, 65535, 1, 0, 0));
        send_request(make_item(0, 0, 300000, 400000, 512, 256, 1, 0));  // only B free
        send_request(make_item(0, 0, 300000, 400000, 512, 256, 0, 1));  // only A free
        send_request(make_item(0, 0, 300000, 400000, 512, 256, 1, 1));  // both pinned
        send_request(make_item(5, 5, 90000, 7000, 0, 0, 0, 0));         // zero total mass
        send_request(make_item(5, 5, 90000, 7000, 0, 300, 0, 0));       // one zero mass
        // Full-span differences force the pre-root shift.
        send_request(make_item(-2147483648, -2147483648, 2147483647, 2147483647,
                               65535, 65535, 0, 0));
        send_request(make_item(2147483647, -2147483648, -2147483648, 2147483647,
                               65535, 1, 0, 0));
        send_request(make_item(-2147483648, 0, 2147483647, 0, 1, 1, 0, 1));
        send_request(make_item(0, -2147483648, 0, 2147483647, 1, 1, 1, 0));
        send_request(make_item(-1, -1, -1, -1, 65535, 65535, 1, 1));
        apply_setting(dcs_pkg::REST_W'(31'h7FFF_FFFF), dcs_pkg::GAIN_ONE, 1'b1);
        // Huge rest length pushes the particles apart into the clamps.
        send_request(make_item(2147483000, 2147483000, 2147482000, 2147482000, 256, 256, 0, 0));
        send_request(make_item(-2147483000, 0, -2147482000, 0, 256, 256, 1, 0));
        send_request(make_item(2147483600, -2147483600, 2147483000, -2147483000, 9, 9, 0, 1));
        // Gain above one, then a gain of zero.
        apply_setting(dcs_pkg::REST_W'(0), dcs_pkg::GAIN_W'(131071), 1'b1);
        send_request(make_item(0, 0, 1000000, -3000000, 100, 900, 0, 0));
        send_request(make_item(0, 0, 1000000, -3000000, 100, 900, 0, 1));
        apply_setting(dcs_pkg::REST_W'(65536), dcs_pkg::GAIN_W'(0), 1'b1);
        send_request(make_item(0, 0, 1000000, -3000000, 100, 900, 0, 0));
        // Disabled.
        apply_setting(dcs_pkg::REST_W'(65536), dcs_pkg::GAIN_ONE, 1'b0);
        send_request(make_item(0, 0, 1000000, -3000000, 100, 900, 0, 0));
        send_request(make_item(-2147483648, 0, 2147483647, 0, 1, 1, 0, 1));
    endtask

    // Random pairs under one setting, with some back-to-back stretches.
    task automatic test_random_phase(logic [dcs_pkg::REST_W-1:0] rest,
                                     logic [dcs_pkg::GAIN_W-1:0] gain,
                                     logic en, int count);
        apply_setting(rest, gain, en);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) idle_free = ($urandom_range(0, 2) == 0);
            send_request(random_pair());
        end
        idle_free = 1'b0;
    endtask

    // The sender holds off until every outstanding result has come, then resumes.
    task automatic test_pause_mid_stream();
        for (int n = 0; n < 20; n++) send_request(random_pair());
        start <= 1'b0;
        while (pending_positions.size() != 0) @(posedge i_clk);
        for (int n = 0; n < 20; n++) send_request(random_pair());
    endtask

    // ---------------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------------

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        dcs_pkg::t_result want;
        if (i_rst_n && o_done) begin
            if (pending_positions.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_positions.pop_front();
                if (o_new_a_x !== want.new_a_x)
                    report_mismatch("new_a_x", o_new_a_x, $signed(want.new_a_x));
                if (o_new_a_y !== want.new_a_y)
                    report_mismatch("new_a_y", o_new_a_y, $signed(want.new_a_y));
                if (o_new_b_x !== want.new_b_x)
                    report_mismatch("new_b_x", o_new_b_x, $signed(want.new_b_x));
                if (o_new_b_y !== want.new_b_y)
                    report_mismatch("new_b_y", o_new_b_y, $signed(want.new_b_y));
                if (o_applied !== want.applied)
                    report_mismatch("applied", o_applied, want.applied);
                if (o_saturated !== want.saturated)
                    report_mismatch("saturated", o_saturated, want.saturated);
            end
        end
    end

    // Watchdog: counts cycles in which no request, result or register write goes through.
    int quiet_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_a_x       = '0;
        i_a_y       = '0;
        i_b_x       = '0;
        i_b_y       = '0;
        i_a_mass    = '0;
        i_b_mass    = '0;
        i_a_pinned  = 1'b0;
        i_b_pinned  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        error_count = 0;
        idle_free   = 1'b0;
        solver_cfg.rest_length    = '0;
        solver_cfg.stiffness_gain = dcs_pkg::GAIN_ONE;
        solver_cfg.enable         = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_phase(dcs_pkg::REST_W'(0), dcs_pkg::GAIN_ONE, 1'b1, 140);
        test_random_phase(dcs_pkg::REST_W'($urandom_range(0, 1 << 20)),
                          dcs_pkg::GAIN_W'($urandom_range(0, 65536)), 1'b1, 140);
        test_pause_mid_stream();
        test_random_phase(dcs_pkg::REST_W'(31'h7FFF_FFFF), dcs_pkg::GAIN_W'(0), 1'b1, 100);
        test_random_phase(dcs_pkg::REST_W'($urandom_range(0, 1 << 24)),
                          dcs_pkg::GAIN_W'(131071), 1'b1, 100);
        test_random_phase(dcs_pkg::REST_W'($urandom),
                          dcs_pkg::GAIN_W'($urandom_range(0, 65536)), 1'b0, 80);
        test_random_phase(dcs_pkg::REST_W'($urandom_range(0, 1 << 18)),
                          dcs_pkg::GAIN_W'(32768), 1'b1, 140);
        test_random_phase(dcs_pkg::REST_W'($urandom), dcs_pkg::GAIN_W'($urandom), 1'b1, 70);

        drain_pipeline();
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

@@ distance_constraint_solver_2d.f @@
+incdir+sv
sv/dcs_pkg.sv
sv/dcs_front.sv
sv/dcs_isqrt.sv
sv/dcs_divide.sv
sv/dcs_correct.sv
sv/distance_constraint_solver_2d.sv
dv/tb_top.sv
